### rtl/ket_pkg.sv
// ----------------------------------------------------------------------------
// ket_pkg
// Shared types, codes and constants for the keyed extent table.
// ----------------------------------------------------------------------------
`default_nettype none

package ket_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;

  localparam logic [2:0] CMD_UPDATE = 3'd0;
  localparam logic [2:0] CMD_FLOOR  = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_ENTRY = 2'd1;
  localparam logic [1:0] WR_KILL  = 2'd2;
  localparam logic [1:0] WR_CLEAR = 2'd3;

  localparam logic signed [31:0] SAT_Q = 32'sh7fff_ffff;

  // search word travelling down the cell chain
  typedef struct packed {
    logic               go;
    logic [2:0]         cmd;
    logic signed [31:0] tag;
    logic signed [31:0] y;
    logic               hit;
    logic signed [31:0] hit_low;
    logic signed [31:0] hit_high;
    logic               free_found;
    logic               best_found;
    logic signed [31:0] best_key;
    logic signed [31:0] best_low;
    logic signed [31:0] best_high;
    logic signed [32:0] best_gap;
  } scan_t;

  // write-back broadcast to all cells
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] low;
    logic signed [31:0] high;
  } wr_t;

endpackage

`default_nettype wire

### rtl/keyed_extent_table_top.sv
// ----------------------------------------------------------------------------
// keyed_extent_table_top
// Bounded tag -> (min, max) elevation table built as a chain of entry cells.
// A command walks the chain one cell per cycle, then a single write-back
// updates the addressed cell and the result word is registered.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_ready | cmd, tag, y_value
//   out     | output    | out_valid/out_ready | found, match_tag, min_y, max_y,
//           |           |                     | table_full, entry_count
//
// One command at a time: a command is registered at the chain head, walks the
// cell chain, is captured at the chain end and then resolved into out. A new
// command is accepted as soon as the previous one has written back, even while
// its result still waits on out.
// A stalled output holds the finished command in the final stage.
// Reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_extent_table_top
  import ket_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [31:0] tag,
  input  wire logic signed [31:0] y_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic signed [31:0]      match_tag,
  output logic signed [31:0]      min_y,
  output logic signed [31:0]      max_y,
  output logic                    table_full,
  output logic [4:0]              entry_count
);

  localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNTW = $clog2(ENTRIES + 1);

  scan_t           word     [0:ENTRIES];
  logic [IDXW-1:0] hit_idx  [0:ENTRIES];
  logic [IDXW-1:0] free_idx [0:ENTRIES];
  logic [CNTW-1:0] cnt      [0:ENTRIES];

  logic            busy;
  logic            done_valid;
  scan_t           done;
  logic [IDXW-1:0] done_hit_idx;
  logic [IDXW-1:0] done_free_idx;
  logic [CNTW-1:0] done_cnt;

  wr_t                wr;
  logic [IDXW-1:0]    wr_idx;
  logic               finish;
  logic               found_next;
  logic signed [31:0] match_tag_next;
  logic signed [31:0] min_next;
  logic signed [31:0] max_next;
  logic               full_next;
  logic [CNTW-1:0]    cnt_next;

  assign in_ready = !busy;
  assign finish   = done_valid && (!out_valid || out_ready);

  // chain head
  always_ff @(posedge clk) begin
    if (rst) begin
      word[0].go <= 1'b0;
    end else begin
      word[0].go <= in_valid && in_ready;
    end
    word[0].cmd        <= cmd;
    word[0].tag        <= tag;
    word[0].y          <= y_value;
    word[0].hit        <= 1'b0;
    word[0].hit_low    <= SAT_Q;
    word[0].hit_high   <= SAT_Q;
    word[0].free_found <= 1'b0;
    word[0].best_found <= 1'b0;
    word[0].best_key   <= '0;
    word[0].best_low   <= SAT_Q;
    word[0].best_high  <= SAT_Q;
    word[0].best_gap   <= '0;
    hit_idx[0]         <= '0;
    free_idx[0]        <= '0;
    cnt[0]             <= '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ket_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .word_in      (word[i]),
      .hit_idx_in   (hit_idx[i]),
      .free_idx_in  (free_idx[i]),
      .cnt_in       (cnt[i]),
      .word_out     (word[i+1]),
      .hit_idx_out  (hit_idx[i+1]),
      .free_idx_out (free_idx[i+1]),
      .cnt_out      (cnt[i+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
  end

  // end of chain capture
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (word[ENTRIES].go) begin
        done_valid <= 1'b1;
      end else if (finish) begin
        done_valid <= 1'b0;
      end
    end
    if (word[ENTRIES].go) begin
      done          <= word[ENTRIES];
      done_hit_idx  <= hit_idx[ENTRIES];
      done_free_idx <= free_idx[ENTRIES];
      done_cnt      <= cnt[ENTRIES];
    end
  end

  // command resolution and write-back
  always_comb begin
    wr.op          = WR_NONE;
    wr.key         = done.tag;
    wr.low         = done.y;
    wr.high        = done.y;
    wr_idx         = done_hit_idx;
    found_next     = 1'b0;
    match_tag_next = done.tag;
    min_next       = SAT_Q;
    max_next       = SAT_Q;
    full_next      = 1'b0;
    cnt_next       = done_cnt;
    unique case (done.cmd)
      CMD_UPDATE: begin
        if (done.hit) begin
          wr.op    = WR_ENTRY;
          wr.low   = (done.y < done.hit_low)  ? done.y : done.hit_low;
          wr.high  = (done.y > done.hit_high) ? done.y : done.hit_high;
          min_next = wr.low;
          max_next = wr.high;
        end else if (done.free_found) begin
          wr.op    = WR_ENTRY;
          wr_idx   = done_free_idx;
          min_next = done.y;
          max_next = done.y;
          cnt_next = done_cnt + CNTW'(1);
        end else begin
          full_next = 1'b1;
        end
      end
      CMD_FLOOR: begin
        match_tag_next = '0;
        if (done.best_found) begin
          found_next     = 1'b1;
          match_tag_next = done.best_key;
          min_next       = done.best_low;
          max_next       = done.best_high;
        end
      end
      CMD_REMOVE: begin
        if (done.hit) begin
          wr.op    = WR_KILL;
          cnt_next = done_cnt - CNTW'(1);
        end
      end
      CMD_CLEAR: begin
        wr.op    = WR_CLEAR;
        cnt_next = '0;
      end
      CMD_QUERY: begin
        if (done.hit) begin
          found_next = 1'b1;
          min_next   = done.hit_low;
          max_next   = done.hit_high;
        end
      end
      default: begin
      end
    endcase
    if (!finish) begin
      wr.op = WR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (finish) begin
      found       <= found_next;
      match_tag   <= match_tag_next;
      min_y       <= min_next;
      max_y       <= max_next;
      table_full  <= full_next;
      entry_count <= 5'(cnt_next);
    end
  end

endmodule

`default_nettype wire

### rtl/ket_cell.sv
// ----------------------------------------------------------------------------
// ket_cell
// One table entry plus one stage of the search chain. Folds its entry into
// the passing search word and applies write-backs addressed to it and table clears.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_cell
  import ket_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT,
  parameter int unsigned IDX     = 0,
  localparam int unsigned IDXW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CNTW   = $clog2(ENTRIES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire scan_t           word_in,
  input  wire logic [IDXW-1:0] hit_idx_in,
  input  wire logic [IDXW-1:0] free_idx_in,
  input  wire logic [CNTW-1:0] cnt_in,
  output scan_t                word_out,
  output logic      [IDXW-1:0] hit_idx_out,
  output logic      [IDXW-1:0] free_idx_out,
  output logic      [CNTW-1:0] cnt_out,
  input  wire wr_t             wr,
  input  wire logic [IDXW-1:0] wr_idx
);

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

  logic               valid;
  logic signed [31:0] key;
  logic signed [31:0] low;
  logic signed [31:0] high;

  scan_t              word_next;
  logic [IDXW-1:0]    hit_idx_next;
  logic [IDXW-1:0]    free_idx_next;
  logic [CNTW-1:0]    cnt_next;
  logic signed [32:0] gap;
  logic               better;

  assign gap = $signed({word_in.y[31], word_in.y}) - $signed({low[31], low});
  assign better = !gap[32] &&
                  (!word_in.best_found || (gap < word_in.best_gap) ||
                   ((gap == word_in.best_gap) && (key < word_in.best_key)));

  always_comb begin
    word_next     = word_in;
    hit_idx_next  = hit_idx_in;
    free_idx_next = free_idx_in;
    cnt_next      = cnt_in;
    if (word_in.go && valid) begin
      cnt_next = cnt_in + CNTW'(1);
      if (key == word_in.tag) begin
        word_next.hit      = 1'b1;
        word_next.hit_low  = low;
        word_next.hit_high = high;
        hit_idx_next       = MY_IDX;
      end
      if (better) begin
        word_next.best_found = 1'b1;
        word_next.best_key   = key;
        word_next.best_low   = low;
        word_next.best_high  = high;
        word_next.best_gap   = gap;
      end
    end
    if (word_in.go && !valid && !word_in.free_found) begin
      word_next.free_found = 1'b1;
      free_idx_next        = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.go <= 1'b0;
    end else begin
      word_out.go <= word_next.go;
    end
    word_out.cmd        <= word_next.cmd;
    word_out.tag        <= word_next.tag;
    word_out.y          <= word_next.y;
    word_out.hit        <= word_next.hit;
    word_out.hit_low    <= word_next.hit_low;
    word_out.hit_high   <= word_next.hit_high;
    word_out.free_found <= word_next.free_found;
    word_out.best_found <= word_next.best_found;
    word_out.best_key   <= word_next.best_key;
    word_out.best_low   <= word_next.best_low;
    word_out.best_high  <= word_next.best_high;
    word_out.best_gap   <= word_next.best_gap;
    hit_idx_out         <= hit_idx_next;
    free_idx_out        <= free_idx_next;
    cnt_out             <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.op == WR_CLEAR) begin
      valid <= 1'b0;
    end else if (wr_idx == MY_IDX) begin
      if (wr.op == WR_ENTRY) begin
        valid <= 1'b1;
      end else if (wr.op == WR_KILL) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((wr.op == WR_ENTRY) && (wr_idx == MY_IDX)) begin
      key  <= wr.key;
      low  <= wr.low;
      high <= wr.high;
    end
  end

endmodule

`default_nettype wire

### verif/tb_keyed_extent_table_top.sv
// ----------------------------------------------------------------------------
// tb_keyed_extent_table_top
// Self-checking bench for the keyed extent table. A queue-fed driver offers
// update, floor search, remove, clear and query words with random gaps, and a
// monitor predicts every accepted word against a shadow table and checks each
// returned word field by field. A directed opening covers the extremes, ties,
// misses and a full table; long random runs over a small tag pool follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyed_extent_table_top;
  import ket_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = ENTRIES_DEFAULT;
  localparam int POOL_SIZE   = 24;

  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam logic signed [31:0] INT_LO = 32'sh8000_0000;
  localparam logic signed [31:0] INT_HI = 32'sh7fff_ffff;
  localparam logic signed [31:0] ONE_Q  = 32'sh0001_0000;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] tag;
    logic signed [31:0] y;
  } table_cmd_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] match_tag;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
    logic               table_full;
    logic [4:0]         entry_count;
  } extent_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         cmd = CMD_UPDATE;
  logic signed [31:0] tag = '0;
  logic signed [31:0] y_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic signed [31:0] match_tag;
  logic signed [31:0] min_y;
  logic signed [31:0] max_y;
  logic               table_full;
  logic [4:0]         entry_count;

  keyed_extent_table_top #(.ENTRIES(TABLE_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .tag         (tag),
    .y_value     (y_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_tag   (match_tag),
    .min_y       (min_y),
    .max_y       (max_y),
    .table_full  (table_full),
    .entry_count (entry_count)
  );

  always #1 clk = ~clk;

  // shadow table
  logic               tbl_live [TABLE_DEPTH];
  logic signed [31:0] tbl_key  [TABLE_DEPTH];
  logic signed [31:0] tbl_low  [TABLE_DEPTH];
  logic signed [31:0] tbl_high [TABLE_DEPTH];

  table_cmd_t         cmd_backlog [$];
  extent_result_t     extent_due [$];
  logic signed [31:0] tag_pool [POOL_SIZE];

  int  cmds_accepted = 0;
  int  mismatches = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic out_hold = 1'b0;
  int  send_wait = 0;
  int  recv_wait = 0;
  bit  send_steady = 1'b0;
  bit  recv_steady = 1'b0;
  table_cmd_t next_word;

  function automatic int slot_of(logic signed [31:0] key);
    int slot;
    slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot < 0 && tbl_live[i] && tbl_key[i] == key) slot = i;
    return slot;
  endfunction

  function automatic extent_result_t apply_cmd(table_cmd_t c);
    extent_result_t     r;
    int                 slot;
    int                 best;
    int                 live_cnt;
    logic signed [32:0] gap;
    logic signed [32:0] best_gap;
    r.found = 1'b0;
    r.match_tag = c.tag;
    r.min_y = SAT_Q;
    r.max_y = SAT_Q;
    r.table_full = 1'b0;
    best = -1;
    best_gap = '0;
    case (c.cmd)
      CMD_UPDATE: begin
        slot = slot_of(c.tag);
        if (slot >= 0) begin
          if (c.y < tbl_low[slot]) tbl_low[slot] = c.y;
          if (c.y > tbl_high[slot]) tbl_high[slot] = c.y;
        end else begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && !tbl_live[i]) slot = i;
          if (slot >= 0) begin
            tbl_live[slot] = 1'b1;
            tbl_key[slot] = c.tag;
            tbl_low[slot] = c.y;
            tbl_high[slot] = c.y;
          end else begin
            r.table_full = 1'b1;
          end
        end
        if (slot >= 0) begin
          r.min_y = tbl_low[slot];
          r.max_y = tbl_high[slot];
        end
      end
      CMD_FLOOR: begin
        r.match_tag = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_live[i]) begin
            gap = $signed({c.y[31], c.y}) - $signed({tbl_low[i][31], tbl_low[i]});
            if (!gap[32] && (best < 0 || gap < best_gap ||
                (gap == best_gap && tbl_key[i] < tbl_key[best]))) begin
              best = i;
              best_gap = gap;
            end
          end
        end
        if (best >= 0) begin
          r.found = 1'b1;
          r.match_tag = tbl_key[best];
          r.min_y = tbl_low[best];
          r.max_y = tbl_high[best];
        end
      end
      CMD_REMOVE: begin
        slot = slot_of(c.tag);
        if (slot >= 0) tbl_live[slot] = 1'b0;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_live[i] = 1'b0;
      end
      CMD_QUERY: begin
        slot = slot_of(c.tag);
        if (slot >= 0) begin
          r.found = 1'b1;
          r.min_y = tbl_low[slot];
          r.max_y = tbl_high[slot];
        end
      end
      default: ;
    endcase
    live_cnt = 0;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_live[i]) live_cnt++;
    r.entry_count = 5'(live_cnt);
    return r;
  endfunction

  task automatic note_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %08h actual %08h", $time, fname, want, got);
    end
  endtask

  task automatic check_result(extent_result_t got);
    extent_result_t want;
    if (extent_due.size() == 0) begin
      mismatches++;
      $display("%0t ns: unexpected result word, expected none actual %p", $time, got);
      return;
    end
    want = extent_due.pop_front();
    note_field("found",       32'(want.found),       32'(got.found));
    note_field("match_tag",   want.match_tag,        got.match_tag);
    note_field("min_y",       want.min_y,            got.min_y);
    note_field("max_y",       want.max_y,            got.max_y);
    note_field("table_full",  32'(want.table_full),  32'(got.table_full));
    note_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
  endtask

  task automatic queue_cmd(logic [2:0] c, logic signed [31:0] t, logic signed [31:0] y);
    cmd_backlog.push_back('{c, t, y});
  endtask

  task automatic refresh_tag_pool();
    tag_pool[0] = INT_LO;
    tag_pool[1] = INT_HI;
    tag_pool[2] = '0;
    tag_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
  endtask

  function automatic table_cmd_t random_cmd();
    table_cmd_t  c;
    int unsigned pick;
    pick = $urandom_range(0, 199);
    if (pick < 90) c.cmd = CMD_UPDATE;
    else if (pick < 130) c.cmd = CMD_FLOOR;
    else if (pick < 160) c.cmd = CMD_QUERY;
    else if (pick < 180) c.cmd = CMD_REMOVE;
    else if (pick < 183) c.cmd = CMD_CLEAR;
    else if (pick < 185) c.cmd = pick[0] ? CMD_RSVD5 : CMD_RSVD7;
    else c.cmd = CMD_UPDATE;
    if ($urandom_range(0, 6) == 0) c.tag = $urandom;
    else c.tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: c.y = INT_LO;
          1: c.y = INT_HI;
          2: c.y = '0;
          default: c.y = -32'sd1;
        endcase
      end
      1, 2, 3, 4: c.y = (int'($urandom_range(0, 8)) - 4) * ONE_Q;
      5, 6: c.y = int'($urandom_range(0, 32'h3ffff)) - 32'sh2_0000;
      default: c.y = $urandom;
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || extent_due.size() != 0) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the word until taken
    end else if (send_wait > 0) begin
      send_wait = send_wait - 1;
      in_valid <= 1'b0;
    end else if (cmd_backlog.size() != 0) begin
      next_word = cmd_backlog.pop_front();
      cmd <= next_word.cmd;
      tag <= next_word.tag;
      y_value <= next_word.y;
      in_valid <= 1'b1;
      if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
      send_wait = send_steady ? 0 : $urandom_range(0, 19);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
      recv_wait = recv_steady ? 0 : $urandom_range(0, 19);
    end
    if (rst || out_hold) begin
      out_ready <= 1'b0;
    end else if (recv_wait > 0) begin
      out_ready <= 1'b0;
      if (out_valid) recv_wait = recv_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst && in_valid && in_ready) begin
      extent_due.push_back(apply_cmd('{cmd, tag, y_value}));
      cmds_accepted++;
    end
    if (!rst && out_valid && out_ready)
      check_result('{found, match_tag, min_y, max_y, table_full, entry_count});
  end

  // long output stall while the sender keeps offering
  initial begin
    wait (cmds_accepted >= 300);
    @(posedge clk);
    out_hold = 1'b1;
    repeat (250) @(posedge clk);
    out_hold = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_live[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_low[i] = '0;
      tbl_high[i] = '0;
    end
    refresh_tag_pool();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_cmd(CMD_QUERY,  32'sd5, '0);
    queue_cmd(CMD_FLOOR,  '0,     '0);
    queue_cmd(CMD_UPDATE, INT_LO, INT_LO);
    queue_cmd(CMD_UPDATE, INT_HI, INT_HI);
    queue_cmd(CMD_UPDATE, INT_LO, INT_HI);
    queue_cmd(CMD_FLOOR,  '0,     INT_HI);
    queue_cmd(CMD_UPDATE, 32'sd3, ONE_Q);
    queue_cmd(CMD_UPDATE, -32'sd3, ONE_Q);
    queue_cmd(CMD_FLOOR,  '0,     ONE_Q + ONE_Q / 2);  // equal gaps, smaller tag
    queue_cmd(CMD_QUERY,  -32'sd3, '0);
    queue_cmd(CMD_REMOVE, 32'sd3, '0);
    queue_cmd(CMD_REMOVE, 32'sd3, '0);
    queue_cmd(CMD_RSVD5,  32'sd7, ONE_Q);
    for (int i = 16; i < 29; i++) queue_cmd(CMD_UPDATE, i, (i - 20) * ONE_Q);
    queue_cmd(CMD_UPDATE, 32'sd29, ONE_Q);              // dropped, table full
    queue_cmd(CMD_UPDATE, -32'sd3, -ONE_Q);
    queue_cmd(CMD_CLEAR,  '0,     '0);
    queue_cmd(CMD_FLOOR,  '0,     '0);
    wait_drained();

    for (int i = 0; i < 700; i++) cmd_backlog.push_back(random_cmd());
    wait_drained();

    refresh_tag_pool();
    for (int i = 0; i < 720; i++) cmd_backlog.push_back(random_cmd());
    wait_drained();

    repeat (TABLE_DEPTH + 12) @(posedge clk);
    if (mismatches == 0 && extent_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
